// ----- rtl/core/efti_pkg.sv -----
// shared types and constants for the escape-time fractal iteration unit
package efti_pkg;

    localparam int CoordWidth  = 32;
    localparam int ProdWidth   = 2 * CoordWidth;
    localparam int OutWidth    = 16;
    localparam int CfgIdxWidth = 3;

    localparam logic [15:0]           MaxIterReset  = 16'd100;
    localparam logic [CoordWidth-1:0] EscLimitReset = 32'h4000_0000;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_KIND     = 3'd0,
        CFG_MAX_ITER = 3'd1,
        CFG_ESC_LIM  = 3'd2,
        CFG_JULIA_RE = 3'd3,
        CFG_JULIA_IM = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR_R,
        ST_SQR_I,
        ST_CROSS,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_in;
        logic     ld_rr;
        logic     ld_ii;
        logic     z_upd;
        logic     out_load;
    } t_ctrl;

endpackage

// ----- rtl/core/efti_mul.sv -----
// shared signed 32x32 multiplier with operand select and registered product
module efti_mul
    import efti_pkg::*;
(
    input  logic                        i_clk,
    input  t_mul_sel                    i_sel,
    input  logic signed [CoordWidth-1:0] i_zr,
    input  logic signed [CoordWidth-1:0] i_zi,
    output logic signed [ProdWidth-1:0]  o_prod
);

    logic signed [CoordWidth-1:0] w_a;
    logic signed [CoordWidth-1:0] w_b;
    logic signed [ProdWidth-1:0]  r_prod;

    always_comb begin
        case (i_sel)
            MUL_RR: begin
                w_a = i_zr;
                w_b = i_zr;
            end
            MUL_II: begin
                w_a = i_zi;
                w_b = i_zi;
            end
            MUL_RI: begin
                w_a = i_zr;
                w_b = i_zi;
            end
            default: begin
                w_a = i_zr;
                w_b = i_zi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ProdWidth'(w_a) * ProdWidth'(w_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/efti_ctrl.sv -----
// sequencer stepping the shared multiplier through each iteration
module efti_ctrl
    import efti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_stop,
    input  logic  i_out_busy,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_ctrl          = '0;
        o_ctrl.mul_sel  = MUL_RR;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_ctrl.ld_in = 1'b1;
                    n_state      = ST_SQR_R;
                end
            end
            ST_SQR_R: begin
                o_ctrl.mul_sel = MUL_RR;
                n_state        = ST_SQR_I;
            end
            ST_SQR_I: begin
                o_ctrl.mul_sel = MUL_II;
                o_ctrl.ld_rr   = 1'b1;
                n_state        = ST_CROSS;
            end
            ST_CROSS: begin
                o_ctrl.mul_sel = MUL_RI;
                o_ctrl.ld_ii   = 1'b1;
                n_state        = ST_STEP;
            end
            ST_STEP: begin
                if (i_stop) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctrl.z_upd = 1'b1;
                    n_state      = ST_SQR_R;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/escape_time_fractal_iteration_unit.sv -----
// top level: config registers, iteration datapath, sequencer and result register
// a new point waits until the last is done
// each iteration runs three products through the one shared 32x32 multiplier in SQR_R, SQR_I
// and CROSS, then a STEP state that stops on escape or at the bound, else updates z
// the finished count sits in an output register so a new point can start behind it
// synchronous active-low reset: config back to mandelbrot, 100 iterations, limit 4.0
module escape_time_fractal_iteration_unit
    import efti_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 28,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // point input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [CoordWidth-1:0] i_point_real,
    input  logic signed [CoordWidth-1:0] i_point_imag,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [OutWidth-1:0]          o_iteration_count,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CfgIdxWidth-1:0]       i_cfg_index,
    input  logic [CoordWidth-1:0]        i_cfg_data
);

    // compare width covers both the counter and the 16-bit register
    localparam int LimWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [LimWidth-1:0] CntMask =
        LimWidth'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic signed [ProdWidth-1:0] SatHi = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ProdWidth-1:0] SatLo = -64'sh0000_0000_8000_0000;

    // config registers
    logic                         r_kind;
    logic [15:0]                  r_max_iter;
    logic [CoordWidth-1:0]        r_esc_lim;
    logic signed [CoordWidth-1:0] r_julia_re;
    logic signed [CoordWidth-1:0] r_julia_im;

    // iteration state
    logic signed [CoordWidth-1:0] r_zr;
    logic signed [CoordWidth-1:0] r_zi;
    logic signed [CoordWidth-1:0] r_cr;
    logic signed [CoordWidth-1:0] r_ci;
    logic signed [ProdWidth-1:0]  r_rr;
    logic signed [ProdWidth-1:0]  r_ii;
    logic [COUNT_WIDTH-1:0]       r_cnt;

    // result register
    logic                         r_out_valid;
    logic [OutWidth-1:0]          r_out_count;

    logic signed [ProdWidth-1:0]  w_prod;
    t_ctrl                        w_ctrl;
    logic                         w_stop;
    logic                         w_out_busy;

    logic [LimWidth-1:0]          w_limit;
    logic [LimWidth-1:0]          w_cnt_ext;
    logic [ProdWidth-1:0]         w_sq_sum;
    logic [ProdWidth-1:0]         w_mag;
    logic                         w_escape;
    logic signed [ProdWidth-1:0]  w_diff;
    logic signed [ProdWidth-1:0]  w_re_sum;
    logic signed [ProdWidth-1:0]  w_im_sum;
    logic signed [CoordWidth-1:0] w_re_sat;
    logic signed [CoordWidth-1:0] w_im_sat;

    assign o_cfg_ready = i_rst_n;

    // config writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= 1'b0;
            r_max_iter <= MaxIterReset;
            r_esc_lim  <= EscLimitReset;
            r_julia_re <= '0;
            r_julia_im <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KIND:     r_kind     <= i_cfg_data[0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                CFG_ESC_LIM:  r_esc_lim  <= i_cfg_data;
                CFG_JULIA_RE: r_julia_re <= i_cfg_data;
                CFG_JULIA_IM: r_julia_im <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    efti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stop     (w_stop),
        .i_out_busy (w_out_busy),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    efti_mul u_mul (
        .i_clk  (i_clk),
        .i_sel  (w_ctrl.mul_sel),
        .i_zr   (r_zr),
        .i_zi   (r_zi),
        .o_prod (w_prod)
    );

    // stop test: count reached the bound or |z|^2 beyond the escape limit
    assign w_limit   = LimWidth'(r_max_iter) & CntMask;
    assign w_cnt_ext = LimWidth'(r_cnt);
    assign w_sq_sum  = $unsigned(r_rr) + $unsigned(r_ii);
    assign w_mag     = w_sq_sum >> COORD_FRAC_BITS;
    assign w_escape  = w_mag > ProdWidth'(r_esc_lim);
    assign w_stop    = (w_cnt_ext >= w_limit) || w_escape;

    // next z: real from the two squares, imag from the cross product doubled
    // arithmetic shifts round toward minus infinity
    assign w_diff   = r_rr - r_ii;
    assign w_re_sum = (w_diff >>> COORD_FRAC_BITS) + ProdWidth'(r_cr);
    assign w_im_sum = (w_prod >>> (COORD_FRAC_BITS - 1)) + ProdWidth'(r_ci);

    always_comb begin
        if (w_re_sum > SatHi) begin
            w_re_sat = SatHi[CoordWidth-1:0];
        end else if (w_re_sum < SatLo) begin
            w_re_sat = SatLo[CoordWidth-1:0];
        end else begin
            w_re_sat = w_re_sum[CoordWidth-1:0];
        end
        if (w_im_sum > SatHi) begin
            w_im_sat = SatHi[CoordWidth-1:0];
        end else if (w_im_sum < SatLo) begin
            w_im_sat = SatLo[CoordWidth-1:0];
        end else begin
            w_im_sat = w_im_sum[CoordWidth-1:0];
        end
    end

    // datapath payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_in) begin
            r_zr <= i_point_real;
            r_zi <= i_point_imag;
            r_cr <= r_kind ? r_julia_re : i_point_real;
            r_ci <= r_kind ? r_julia_im : i_point_imag;
        end else if (w_ctrl.z_upd) begin
            r_zr <= w_re_sat;
            r_zi <= w_im_sat;
        end
        if (w_ctrl.ld_rr) begin
            r_rr <= w_prod;
        end
        if (w_ctrl.ld_ii) begin
            r_ii <= w_prod;
        end
        if (w_ctrl.out_load) begin
            r_out_count <= w_cnt_ext[OutWidth-1:0];
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_ctrl.ld_in) begin
            r_cnt <= '0;
        end else if (w_ctrl.z_upd) begin
            r_cnt <= r_cnt + COUNT_WIDTH'(1);
        end
    end

    // result beat holds until taken; a new load wins over a take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_out_busy        = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;

`ifndef ASSERT_OFF
    a_cnt_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_cnt == '0))
        else $error("count not cleared on point beat");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.z_upd |=> (r_cnt == $past(r_cnt) + COUNT_WIDTH'(1)))
        else $error("count did not advance on iteration");

    a_upd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.z_upd |-> (w_cnt_ext < w_limit))
        else $error("iteration past the configured bound");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> !w_out_busy)
        else $error("result overwritten before taken");
`endif

endmodule

// ----- test/tb_escape_time_fractal_iteration_unit.sv -----
// testbench for the escape-time fractal iteration unit: directed and random points, scored per beat
module tb_escape_time_fractal_iteration_unit
    import efti_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FracBits    = 28;
    localparam int CountWidth  = 16;
    localparam int ClkPeriod   = 2;
    localparam int GapMax      = 16;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 64;
    // longest quiet stretch: one point running the full count, plus stalls and the hold
    localparam int QuietLimit  = 3 * (4 * 65535 + 6 + 2 * GapMax + HoldCycles);

    // Q4.28 values used by the directed tests
    localparam logic signed [CoordWidth-1:0] CoordMax  = 32'sh7FFF_FFFF;
    localparam logic signed [CoordWidth-1:0] CoordMin  = 32'sh8000_0000;
    localparam logic signed [CoordWidth-1:0] CoordOne  = 32'sh1000_0000;
    localparam logic signed [CoordWidth-1:0] CoordTwo  = 32'sh2000_0000;
    localparam logic signed [CoordWidth-1:0] CoordNear = 32'sh1E66_6666;  // 1.9
    localparam logic signed [CoordWidth-1:0] CoordTiny = -32'sd1;         // -2^-28
    localparam logic [CoordWidth-1:0]        LimitMax  = 32'hFFFF_FFFF;

    // wide clamp bounds for the z update
    localparam logic signed [ProdWidth-1:0] WideMax = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ProdWidth-1:0] WideMin = -64'sh0000_0000_8000_0000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic signed [CoordWidth-1:0] i_point_real;
    logic signed [CoordWidth-1:0] i_point_imag;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [OutWidth-1:0]          o_iteration_count;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CfgIdxWidth-1:0]       i_cfg_index;
    logic [CoordWidth-1:0]        i_cfg_data;

    // shadow copy of the config registers
    logic                         shadow_julia;
    logic [15:0]                  shadow_max_iter;
    logic [CoordWidth-1:0]        shadow_esc_limit;
    logic signed [CoordWidth-1:0] shadow_c_re;
    logic signed [CoordWidth-1:0] shadow_c_im;

    // predicted counts, oldest first
    logic [OutWidth-1:0] pending_counts[$];

    int          fail_count      = 0;
    int unsigned in_gap_max      = GapMax;
    int unsigned out_gap_max     = GapMax;
    int unsigned hold_off_cycles = 0;
    int unsigned quiet_cycles;

    escape_time_fractal_iteration_unit #(
        .COORD_FRAC_BITS(FracBits),
        .COUNT_WIDTH    (CountWidth)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_point_real     (i_point_real),
        .i_point_imag     (i_point_imag),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_iteration_count(o_iteration_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic signed [ProdWidth-1:0] clamp_coord(
        input logic signed [ProdWidth-1:0] v
    );
        if (v > WideMax) return WideMax;
        if (v < WideMin) return WideMin;
        return v;
    endfunction

    // escape-time count of one point under the shadow config
    function automatic logic [OutWidth-1:0] escape_count(
        input logic signed [CoordWidth-1:0] p_re,
        input logic signed [CoordWidth-1:0] p_im
    );
        logic signed [ProdWidth-1:0] zr, zi, cr, ci, rr, ii, nr, ni;
        logic [ProdWidth-1:0]        mag;
        logic [CountWidth-1:0]       bound;
        logic [CountWidth-1:0]       n;
        zr    = ProdWidth'(p_re);
        zi    = ProdWidth'(p_im);
        cr    = ProdWidth'(shadow_julia ? shadow_c_re : p_re);
        ci    = ProdWidth'(shadow_julia ? shadow_c_im : p_im);
        bound = shadow_max_iter;
        n     = '0;
        while (n < bound) begin
            rr  = zr * zr;
            ii  = zi * zi;
            // the sum of squares can reach 2^63, so add as unsigned
            mag = ($unsigned(rr) + $unsigned(ii)) >> FracBits;
            if (mag > ProdWidth'(shadow_esc_limit)) break;
            // arithmetic shifts floor toward minus infinity
            nr = ((rr - ii) >>> FracBits) + cr;
            // 2*zr*zi is one bit less of rescale
            ni = ((zr * zi) >>> (FracBits - 1)) + ci;
            zr = clamp_coord(nr);
            zi = clamp_coord(ni);
            n++;
        end
        return OutWidth'(n);
    endfunction

    // ---------------------------------------------------------------
    // shared drivers
    // ---------------------------------------------------------------

    // one point beat, after a random gap; valid stays up across back-to-back beats
    task automatic send_point(
        input logic signed [CoordWidth-1:0] re,
        input logic signed [CoordWidth-1:0] im
    );
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_real <= re;
        i_point_imag <= im;
        do @(posedge i_clk); while (!o_in_ready);
        pending_counts.push_back(escape_count(re, im));
    endtask

    // stop offering points and wait until every count is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    // one register beat; valid is left high for a following write
    task automatic write_reg(
        input logic [CfgIdxWidth-1:0] idx,
        input logic [CoordWidth-1:0]  data
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (t_cfg_idx'(idx))
            CFG_KIND:     shadow_julia     = data[0];
            CFG_MAX_ITER: shadow_max_iter  = data[15:0];
            CFG_ESC_LIM:  shadow_esc_limit = data;
            CFG_JULIA_RE: shadow_c_re      = data;
            CFG_JULIA_IM: shadow_c_im      = data;
            default: ;  // unused indexes are dropped by the block
        endcase
    endtask

    // drain, then program all five registers
    task automatic set_mode(
        input logic [CoordWidth-1:0] kind_word,
        input logic [CoordWidth-1:0] max_word,
        input logic [CoordWidth-1:0] limit,
        input logic [CoordWidth-1:0] c_re,
        input logic [CoordWidth-1:0] c_im
    );
        wait_idle();
        write_reg(CFG_KIND, kind_word);
        write_reg(CFG_MAX_ITER, max_word);
        write_reg(CFG_ESC_LIM, limit);
        write_reg(CFG_JULIA_RE, c_re);
        write_reg(CFG_JULIA_IM, c_im);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly inside |x| <= 2, sometimes anywhere in the field
    function automatic logic signed [CoordWidth-1:0] draw_coord();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $signed($urandom_range(0, 2 * CoordTwo)) - CoordTwo;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset config: mandelbrot, 100 iterations, limit 4.0
    task automatic test_reset_defaults();
        send_point(0, 0);
        send_point(-CoordTwo, 0);        // sits on |z|^2 == limit forever
        send_point(0, CoordOne);         // period-two orbit
        send_point(CoordMax, CoordMax);
        send_point(CoordMin, CoordMin);
        send_point(CoordTiny, CoordTiny);
    endtask

    // zero maximum, excess data bits, unused indexes
    task automatic test_config_writes();
        wait_idle();
        write_reg(CFG_MAX_ITER, 32'hABCD_0000);
        for (int k = int'(CFG_JULIA_IM) + 1; k < (1 << CfgIdxWidth); k++)
            write_reg(CfgIdxWidth'(k), 32'hFFFF_FFFF);
        write_reg(CFG_KIND, 32'hFFFF_FFFE);
        write_reg(CFG_JULIA_RE, 32'hFFFF_FFFF);
        write_reg(CFG_JULIA_IM, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_point(0, 0);
        send_point(CoordMax, 0);
        wait_idle();
        write_reg(CFG_MAX_ITER, 32'h1234_0003);
        write_reg(CFG_KIND, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_point(CoordOne >>> 1, 0);
        send_point(0, 0);
    endtask

    // limit of zero and all ones, rounding of tiny magnitudes, z saturation
    task automatic test_escape_limits();
        set_mode(0, 16, 0, 0, 0);
        send_point(CoordTiny, CoordTiny);  // |z|^2 truncates to zero
        send_point(0, 1);
        send_point(CoordOne, 0);
        set_mode(0, 40, LimitMax, 0, 0);
        send_point(CoordNear, CoordNear);   // imaginary part clamps high
        send_point(CoordNear, -CoordNear);  // imaginary part clamps low
        send_point(-CoordTwo, -CoordTwo);
        send_point(CoordMin, 0);
    endtask

    // julia mode, ordinary constant and constants at the field extremes
    task automatic test_julia();
        set_mode(1, 64, EscLimitReset, -32'sh0CCC_CCCD, 32'sh027E_F9DB);
        send_point(0, 0);
        send_point(32'sh04CC_CCCD, -32'sh0666_6666);
        send_point(CoordMin, CoordMax);
        set_mode(1, 12, LimitMax, CoordMin, CoordMax);
        send_point(0, 0);
        send_point(CoordOne, CoordTiny);
    endtask

    // the full 16-bit count, and a slow escape just outside the cardioid cusp
    task automatic test_long_count();
        set_mode(0, 32'h0000_FFFF, EscLimitReset, 0, 0);
        send_point(0, 0);
        send_point(32'sh0400_1000, 0);
    endtask

    // receiver holds off while points keep coming, so the input stalls
    task automatic test_backpressure();
        set_mode(0, 8, EscLimitReset, 0, 0);
        in_gap_max      = 0;
        out_gap_max     = 0;
        hold_off_cycles = HoldCycles;
        repeat (24) send_point(draw_coord(), draw_coord());
    endtask

    // random config per phase, idling on one side, both or neither
    task automatic test_random_phases();
        logic [15:0]           iters;
        logic [CoordWidth-1:0] kind_junk, max_junk, limit;
        for (int p = 0; p < 9; p++) begin
            iters = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(49, 300))
                                                : 16'($urandom_range(1, 48));
            limit = ($urandom_range(0, 3) == 0) ? $urandom()
                                                : $urandom_range(32'h0800_0000, 32'h8000_0000);
            kind_junk = $urandom();
            max_junk  = $urandom();
            set_mode({kind_junk[31:1], 1'($urandom_range(0, 1))},
                     {max_junk[31:16], iters}, limit, draw_coord(), draw_coord());
            in_gap_max  = (p % 2 == 1) ? 0 : GapMax;
            out_gap_max = (p % 4 >= 2) ? 0 : GapMax;
            repeat (48) send_point(draw_coord(), draw_coord());
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver: random stall before each beat, or one long hold when asked
    initial begin
        int unsigned stall;
        i_out_ready <= 1'b0;
        forever begin
            if (hold_off_cycles != 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = $urandom_range(0, out_gap_max);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // scoreboard: each count beat against the oldest prediction
    always @(posedge i_clk) begin : score_counts
        logic [OutWidth-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_counts.size() == 0) begin
                $error("iteration_count beat with no point pending: actual %0d",
                       o_iteration_count);
                fail_count++;
            end else begin
                want = pending_counts.pop_front();
                if (o_iteration_count !== want) begin
                    $error("iteration_count mismatch: expected %0d, actual %0d",
                           want, o_iteration_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any beat on any channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QuietLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("escape_time_fractal_iteration_unit verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_point_real <= '0;
        i_point_imag <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_KIND;
        i_cfg_data   <= '0;
        shadow_julia     = 1'b0;
        shadow_max_iter  = MaxIterReset;
        shadow_esc_limit = EscLimitReset;
        shadow_c_re      = '0;
        shadow_c_im      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_writes();
        test_escape_limits();
        test_julia();
        test_long_count();
        test_backpressure();
        test_random_phases();

        wait_idle();
        // catch any stray beat after the last count
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("escape_time_fractal_iteration_unit verification clean");
        end else begin
            $display("escape_time_fractal_iteration_unit verification failed");
        end
        $finish;
    end

endmodule
